### hw/rtl/fisheye_to_rectilinear_remap_core_defines.svh
// Assertion macros for the fisheye remap core.
`ifndef FISHEYE_TO_RECTILINEAR_REMAP_CORE_DEFINES_SVH
`define FISHEYE_TO_RECTILINEAR_REMAP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define FR_CHECK(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("fisheye remap check failed");
`define FR_CHECK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fisheye remap check failed");
`else
`define FR_CHECK(lbl, expr)
`define FR_CHECK_IMP(lbl, ante, cons)
`endif
`endif

### hw/rtl/fr_remap_pkg.sv
package fr_remap_pkg;

  localparam int DEST_W    = 12;
  localparam int DIM_W     = 13;
  localparam int SRC_W     = 12;
  localparam int FOCAL_W   = 32;
  localparam int PPR_W     = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_DIMENSION = 4096;
  localparam int DEF_CORDIC_STEPS  = 16;

  localparam logic [DIM_W-1:0]   RST_IMAGE_DIM = DIM_W'(4096);
  localparam logic [FOCAL_W-1:0] RST_INV_FOCAL = 32'h0100_0000;
  localparam logic [PPR_W-1:0]   RST_PPR       = 32'h0001_0000;

  // datapath widths
  localparam int D2_W      = DIM_W + 2;          // signed half-pixel offset
  localparam int MAG_W     = DIM_W;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUM_W     = SQ_W + 1;
  localparam int RAD_FRAC  = 16;
  localparam int RAD_W     = SUM_W + RAD_FRAC;
  localparam int R_W       = (RAD_W + 1) / 2;
  localparam int P_W       = R_W + FOCAL_W;
  localparam int CW        = P_W + 3;            // cordic x/y, signed
  localparam int X0_SH     = 33;
  localparam int Z_W       = 33;
  localparam int PHI_W     = 31;
  localparam int ANG_FRAC  = 30;
  localparam int ATAN_W    = 32;
  localparam int RS_W      = PHI_W + PPR_W - ANG_FRAC;
  localparam int OFF_SH    = 8;
  localparam int NUM_W     = RS_W + MAG_W + OFF_SH;
  localparam int CTR_SH    = 15;
  localparam int SRC_FRAC  = 16;
  localparam int SRC_INT_W = NUM_W + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_INVERSE_FOCAL,
    REG_PIXELS_PER_RADIAN
  } cfg_reg_t;

  // atan(2^-i), Q30, truncated
  function automatic logic [ATAN_W-1:0] atan_q30(input logic [4:0] idx);
    logic [ATAN_W-1:0] a;
    unique case (idx)
      5'd0:  a = 32'h3243F6A8;
      5'd1:  a = 32'h1DAC6705;
      5'd2:  a = 32'h0FADBAFC;
      5'd3:  a = 32'h07F56EA6;
      5'd4:  a = 32'h03FEAB76;
      5'd5:  a = 32'h01FFD55B;
      5'd6:  a = 32'h00FFFAAA;
      5'd7:  a = 32'h007FFF55;
      5'd8:  a = 32'h003FFFEA;
      5'd9:  a = 32'h001FFFFD;
      5'd10: a = 32'h000FFFFF;
      5'd11: a = 32'h0007FFFF;
      5'd12: a = 32'h0003FFFF;
      5'd13: a = 32'h0001FFFF;
      5'd14: a = 32'h0000FFFF;
      5'd15: a = 32'h00007FFF;
      5'd16: a = 32'h00003FFF;
      5'd17: a = 32'h00001FFF;
      5'd18: a = 32'h00000FFF;
      5'd19: a = 32'h000007FF;
      5'd20: a = 32'h000003FF;
      5'd21: a = 32'h000001FF;
      5'd22: a = 32'h000000FF;
      5'd23: a = 32'h0000007F;
      5'd24: a = 32'h0000003F;
      5'd25: a = 32'h0000001F;
      5'd26: a = 32'h0000000F;
      5'd27: a = 32'h00000007;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000000;
      5'd31: a = 32'h00000000;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### hw/rtl/fisheye_to_rectilinear_remap_core.sv
// Fisheye to rectilinear coordinate remap, fully pipelined.
// Depth: 22 square-root stages, one stage per CORDIC rotation and 54 divider stages
//   make up most of the pipeline.
// Throughput: one coordinate per clock; a stalled output freezes the whole pipe.
// Reset: synchronous, clears all valid bits and loads the register defaults.
`include "fisheye_to_rectilinear_remap_core_defines.svh"

module fisheye_to_rectilinear_remap_core import fr_remap_pkg::*; #(
  parameter int MAX_DIMENSION = DEF_MAX_DIMENSION,
  parameter int CORDIC_STEPS  = DEF_CORDIC_STEPS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DEST_W-1:0]    dest_x,
  input  logic [DEST_W-1:0]    dest_y,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SRC_W-1:0]     source_x,
  output logic [SRC_W-1:0]     source_y,
  output logic                 out_of_range
);

  typedef struct packed {
    logic [SRC_W-1:0] coord;
    logic             oor;
  } axis_t;

  localparam int SQ_SIDE_W = 2 * D2_W;
  localparam int CO_SIDE_W = R_W + 2 * D2_W;
  localparam logic signed [SRC_INT_W-1:0] ONE_PIX = signed'(SRC_INT_W'(1) << SRC_FRAC);

  function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] d;
    if (v == '0) begin
      d = DIM_W'(1);
    end else if (32'(v) > 32'(MAX_DIMENSION)) begin
      d = DIM_W'(MAX_DIMENSION);
    end else begin
      d = v;
    end
    return d;
  endfunction

  function automatic axis_t map_axis(input logic [NUM_W-1:0] q, input logic neg,
                                     input logic rzero, input logic [DIM_W-1:0] dim);
    logic signed [SRC_INT_W-1:0] off, ctr, src, ip, lim;
    logic [DIM_W-1:0] dm1;
    axis_t r;
    dm1 = dim - DIM_W'(1);
    off = rzero ? '0 : signed'(SRC_INT_W'(q));
    ctr = signed'(SRC_INT_W'(dm1) << CTR_SH);
    src = neg ? ctr - off : ctr + off;
    ip  = src >>> SRC_FRAC;
    lim = src + ONE_PIX;
    if (src[SRC_INT_W-1]) begin
      // fractions in (-1,0) truncate to zero without a flag
      r.coord = '0;
      r.oor   = lim[SRC_INT_W-1] || (lim == '0);
    end else if (ip >= signed'(SRC_INT_W'(dim))) begin
      r.coord = dm1[SRC_W-1:0];
      r.oor   = 1'b1;
    end else begin
      r.coord = ip[SRC_W-1:0];
      r.oor   = 1'b0;
    end
    return r;
  endfunction

  // configuration
  logic [DIM_W-1:0]   image_width, image_height;
  logic [FOCAL_W-1:0] inverse_focal;
  logic [PPR_W-1:0]   pixels_per_radian;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= RST_IMAGE_DIM;
      image_height      <= RST_IMAGE_DIM;
      inverse_focal     <= RST_INV_FOCAL;
      pixels_per_radian <= RST_PPR;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:       image_width       <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:      image_height      <= cfg_data[DIM_W-1:0];
        REG_INVERSE_FOCAL:     inverse_focal     <= cfg_data[FOCAL_W-1:0];
        REG_PIXELS_PER_RADIAN: pixels_per_radian <= cfg_data[PPR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] w_eff, h_eff, w_m1, h_m1;
  assign w_eff = dim_eff(image_width);
  assign h_eff = dim_eff(image_height);
  assign w_m1  = w_eff - DIM_W'(1);
  assign h_m1  = h_eff - DIM_W'(1);

  // one enable for the whole pipe
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage a: half-pixel offsets
  logic                   a_vld;
  logic signed [D2_W-1:0] a_dx2, a_dy2;

  // stage b: squares
  logic                       b_vld;
  logic [SQ_W-1:0]            b_sqx, b_sqy;
  logic signed [D2_W-1:0]     b_dx2, b_dy2;
  logic signed [2*D2_W-1:0]   sqx_full, sqy_full;

  // stage c: sum of squares
  logic                   c_vld;
  logic [SUM_W-1:0]       c_sum;
  logic signed [D2_W-1:0] c_dx2, c_dy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
      b_vld <= a_vld;
      c_vld <= b_vld;
    end
  end

  assign sqx_full = a_dx2 * a_dx2;
  assign sqy_full = a_dy2 * a_dy2;

  always_ff @(posedge clk) begin
    if (en) begin
      a_dx2 <= signed'({2'b00, dest_x, 1'b0}) - signed'({2'b00, w_m1});
      a_dy2 <= signed'({2'b00, dest_y, 1'b0}) - signed'({2'b00, h_m1});
      b_sqx <= sqx_full[SQ_W-1:0];
      b_sqy <= sqy_full[SQ_W-1:0];
      b_dx2 <= a_dx2;
      b_dy2 <= a_dy2;
      c_sum <= {1'b0, b_sqx} + {1'b0, b_sqy};
      c_dx2 <= b_dx2;
      c_dy2 <= b_dy2;
    end
  end

  // radius
  logic                 sq_vld;
  logic [R_W-1:0]       sq_r;
  logic [SQ_SIDE_W-1:0] sq_side;

  fr_remap_isqrt #(.SIDE_W(SQ_SIDE_W)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (c_vld),
    .rad      ({c_sum, RAD_FRAC'(0)}),
    .side_in  ({c_dx2, c_dy2}),
    .out_vld  (sq_vld),
    .root     (sq_r),
    .side_out (sq_side)
  );

  // stage d: radius times inverse focal
  logic                 d_vld;
  logic [P_W-1:0]       d_p, p_prod;
  logic [CO_SIDE_W-1:0] d_side;

  assign p_prod = P_W'(sq_r) * P_W'(inverse_focal);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en) begin
      d_vld <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_p    <= p_prod;
      d_side <= {sq_r, sq_side};
    end
  end

  // angle
  logic                 co_vld;
  logic [PHI_W-1:0]     co_phi;
  logic [CO_SIDE_W-1:0] co_side;

  fr_remap_cordic #(.STEPS(CORDIC_STEPS), .SIDE_W(CO_SIDE_W)) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (d_vld),
    .p        (d_p),
    .side_in  (d_side),
    .out_vld  (co_vld),
    .phi      (co_phi),
    .side_out (co_side)
  );

  // stage e: source radius
  logic                        e_vld;
  logic [RS_W-1:0]             e_rs;
  logic [R_W-1:0]              e_r;
  logic signed [D2_W-1:0]      e_dx2, e_dy2;
  logic [PHI_W+PPR_W-1:0]      phi_prod;

  assign phi_prod = (PHI_W + PPR_W)'(co_phi) * (PHI_W + PPR_W)'(pixels_per_radian);

  // stage f: scaled numerators
  logic                     f_vld, f_negx, f_negy, f_rzero;
  logic [NUM_W-1:0]         f_nx, f_ny;
  logic [R_W-1:0]           f_r;
  logic [MAG_W-1:0]         magx, magy;
  logic [RS_W+MAG_W-1:0]    prod_x, prod_y;

  assign magx   = e_dx2[D2_W-1] ? MAG_W'(-e_dx2) : MAG_W'(e_dx2);
  assign magy   = e_dy2[D2_W-1] ? MAG_W'(-e_dy2) : MAG_W'(e_dy2);
  assign prod_x = (RS_W + MAG_W)'(e_rs) * (RS_W + MAG_W)'(magx);
  assign prod_y = (RS_W + MAG_W)'(e_rs) * (RS_W + MAG_W)'(magy);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
      f_vld <= 1'b0;
    end else if (en) begin
      e_vld <= co_vld;
      f_vld <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_rs    <= phi_prod[PHI_W+PPR_W-1:ANG_FRAC];
      e_r     <= co_side[CO_SIDE_W-1 -: R_W];
      e_dx2   <= co_side[2*D2_W-1 -: D2_W];
      e_dy2   <= co_side[D2_W-1:0];
      f_nx    <= {prod_x, OFF_SH'(0)};
      f_ny    <= {prod_y, OFF_SH'(0)};
      f_negx  <= e_dx2[D2_W-1];
      f_negy  <= e_dy2[D2_W-1];
      f_r     <= e_r;
      f_rzero <= (e_r == '0);
    end
  end

  // division by radius, one divider per axis
  logic             qx_vld, qy_vld, q_negy;
  logic [NUM_W-1:0] qx, qy;
  logic [1:0]       qx_side;

  fr_remap_div #(.SIDE_W(2)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (f_vld),
    .num      (f_nx),
    .den      (f_r),
    .side_in  ({f_negx, f_rzero}),
    .out_vld  (qx_vld),
    .quo      (qx),
    .side_out (qx_side)
  );

  fr_remap_div #(.SIDE_W(1)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (f_vld),
    .num      (f_ny),
    .den      (f_r),
    .side_in  (f_negy),
    .out_vld  (qy_vld),
    .quo      (qy),
    .side_out (q_negy)
  );

  // output stage: recenter, clamp, flag
  axis_t ax, ay;
  assign ax = map_axis(qx, qx_side[1], qx_side[0], w_eff);
  assign ay = map_axis(qy, q_negy, qx_side[0], h_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= qx_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      source_x     <= ax.coord;
      source_y     <= ay.coord;
      out_of_range <= ax.oor || ay.oor;
    end
  end

  `FR_CHECK(a_div_lanes_aligned, qx_vld == qy_vld)
  `FR_CHECK_IMP(a_center_zero_num, f_vld && f_rzero, (f_nx == '0) && (f_ny == '0))
  `FR_CHECK_IMP(a_out_from_div, $rose(out_valid), $past(qx_vld))

endmodule

### hw/rtl/fr_remap_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module fr_remap_isqrt import fr_remap_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [RAD_W-1:0]  rad,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_vld,
  output logic [R_W-1:0]    root,
  output logic [SIDE_W-1:0] side_out
);

  logic              vld [1:R_W];
  logic [RAD_W-1:0]  v   [1:R_W];
  logic [RAD_W:0]    res [1:R_W];
  logic [SIDE_W-1:0] sd  [1:R_W];

  for (genvar k = 0; k < R_W; k++) begin : g_stage
    localparam int SH = 2 * (R_W - 1 - k);
    localparam logic [RAD_W:0] BIT = (RAD_W + 1)'(1) << SH;

    logic              cvld;
    logic [RAD_W-1:0]  cv, nv;
    logic [RAD_W:0]    cr, rb, nr;
    logic [SIDE_W-1:0] cs;

    if (k == 0) begin : g_first
      assign cvld = in_vld;
      assign cv   = rad;
      assign cr   = '0;
      assign cs   = side_in;
    end else begin : g_mid
      assign cvld = vld[k];
      assign cv   = v[k];
      assign cr   = res[k];
      assign cs   = sd[k];
    end

    always_comb begin
      rb = cr + BIT;
      if ({1'b0, cv} >= rb) begin
        nv = cv - rb[RAD_W-1:0];
        nr = (cr >> 1) + BIT;
      end else begin
        nv = cv;
        nr = cr >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= cvld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v[k+1]   <= nv;
        res[k+1] <= nr;
        sd[k+1]  <= cs;
      end
    end
  end

  assign out_vld  = vld[R_W];
  assign root     = res[R_W][R_W-1:0];
  assign side_out = sd[R_W];

endmodule

### hw/rtl/fr_remap_cordic.sv
// Pipelined CORDIC in vectoring mode: angle of (2^33, p), one rotation per stage.
module fr_remap_cordic import fr_remap_pkg::*; #(
  parameter int STEPS  = DEF_CORDIC_STEPS,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [P_W-1:0]    p,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_vld,
  output logic [PHI_W-1:0]  phi,
  output logic [SIDE_W-1:0] side_out
);

  localparam logic signed [CW-1:0] X_INIT = signed'(CW'(1) << X0_SH);

  logic                  vld [1:STEPS];
  logic signed [CW-1:0]  xr  [1:STEPS];
  logic signed [CW-1:0]  yr  [1:STEPS];
  logic signed [Z_W-1:0] zr  [1:STEPS];
  logic [SIDE_W-1:0]     sd  [1:STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    localparam int SH = i % 32;

    logic                  cvld, pos;
    logic signed [CW-1:0]  cx, cy, xs, ys, nx, ny;
    logic signed [Z_W-1:0] cz, ang, nz;
    logic [SIDE_W-1:0]     cs;

    if (i == 0) begin : g_first
      assign cvld = in_vld;
      assign cx   = X_INIT;
      assign cy   = signed'(CW'(p));
      assign cz   = '0;
      assign cs   = side_in;
    end else begin : g_mid
      assign cvld = vld[i];
      assign cx   = xr[i];
      assign cy   = yr[i];
      assign cz   = zr[i];
      assign cs   = sd[i];
    end

    always_comb begin
      xs  = cx >>> SH;
      ys  = cy >>> SH;
      ang = signed'(Z_W'(atan_q30(5'(SH))));
      pos = !cy[CW-1] && (cy != '0);
      if (pos) begin
        nx = cx + ys;
        ny = cy - xs;
        nz = cz + ang;
      end else begin
        nx = cx - ys;
        ny = cy + xs;
        nz = cz - ang;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= cvld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xr[i+1] <= nx;
        yr[i+1] <= ny;
        zr[i+1] <= nz;
        sd[i+1] <= cs;
      end
    end
  end

  // negative angle clips to zero
  assign out_vld  = vld[STEPS];
  assign phi      = zr[STEPS][Z_W-1] ? '0 : zr[STEPS][PHI_W-1:0];
  assign side_out = sd[STEPS];

endmodule

### hw/rtl/fr_remap_div.sv
// Pipelined restoring divider, one quotient bit per stage; divisor travels along.
module fr_remap_div import fr_remap_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  num,
  input  logic [R_W-1:0]    den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_vld,
  output logic [NUM_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  logic              vld [1:NUM_W];
  logic [R_W-1:0]    rem [1:NUM_W];
  logic [NUM_W-1:0]  nq  [1:NUM_W];
  logic [R_W-1:0]    dv  [1:NUM_W];
  logic [SIDE_W-1:0] sd  [1:NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              cvld, ge;
    logic [R_W-1:0]    crem, cden, nrem;
    logic [R_W:0]      rext;
    logic [NUM_W-1:0]  cnq;
    logic [SIDE_W-1:0] cs;

    if (k == 0) begin : g_first
      assign cvld = in_vld;
      assign crem = '0;
      assign cnq  = num;
      assign cden = den;
      assign cs   = side_in;
    end else begin : g_mid
      assign cvld = vld[k];
      assign crem = rem[k];
      assign cnq  = nq[k];
      assign cden = dv[k];
      assign cs   = sd[k];
    end

    always_comb begin
      rext = {crem, cnq[NUM_W-1]};
      ge   = (rext >= {1'b0, cden});
      if (ge) begin
        nrem = R_W'(rext - {1'b0, cden});
      end else begin
        nrem = rext[R_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= cvld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= nrem;
        nq[k+1]  <= {cnq[NUM_W-2:0], ge};
        dv[k+1]  <= cden;
        sd[k+1]  <= cs;
      end
    end
  end

  assign out_vld  = vld[NUM_W];
  assign quo      = nq[NUM_W];
  assign side_out = sd[NUM_W];

endmodule

### tb/sv/tb_fisheye_to_rectilinear_remap_core.sv
module tb_fisheye_to_rectilinear_remap_core;
  import fr_remap_pkg::*;

  typedef struct {
    logic [DEST_W-1:0] x;
    logic [DEST_W-1:0] y;
  } dest_beat_t;

  typedef struct {
    logic [SRC_W-1:0] x;
    logic [SRC_W-1:0] y;
    logic             oor;
  } source_beat_t;

  // atan(2^-i) in Q30, truncated
  localparam longint ARCTAN_Q30 [16] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
  };

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [DEST_W-1:0]    dest_x;
  logic [DEST_W-1:0]    dest_y;
  logic                 out_valid;
  logic                 out_stall;
  logic [SRC_W-1:0]     source_x;
  logic [SRC_W-1:0]     source_y;
  logic                 out_of_range;

  fisheye_to_rectilinear_remap_core dut (.*);

  longint       img_w, img_h, inv_focal, px_per_rad;
  dest_beat_t   dest_pending[$];
  source_beat_t source_expected[$];
  int           send_idle_pct, recv_idle_pct;
  int           errors, n_checked, n_oor;
  int           hold_cycles;
  bit           took_beat;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Timeout at %0t", $time);
    $display("Some tests failed");
    $finish;
  end

  function automatic longint int_sqrt(input longint v);
    longint res, b;
    res = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic longint fold_angle(input longint p);
    longint x, y, z, xs, ys;
    x = 64'sd1 <<< 33;
    y = p;
    z = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN_Q30[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN_Q30[i];
      end
    end
    return (z < 0) ? 0 : z;
  endfunction

  function automatic longint clamp_dim(input longint v);
    if (v < 1) return 1;
    if (v > 4096) return 4096;
    return v;
  endfunction

  function automatic longint place_axis(input longint d2, input longint dim,
                                        input longint rs, input longint r,
                                        inout logic oor);
    longint mag, off, src, ip;
    mag = (d2 < 0) ? -d2 : d2;
    off = 0;
    if (r != 0) off = ((rs * mag) <<< 8) / r;
    src = ((dim - 1) <<< 15) + ((d2 < 0) ? -off : off);
    if (src < 0) begin
      if (src <= -65536) oor = 1'b1;
      return 0;
    end
    ip = src >>> 16;
    if (ip >= dim) begin
      oor = 1'b1;
      return dim - 1;
    end
    return ip;
  endfunction

  function automatic source_beat_t remap_coord(input dest_beat_t d);
    source_beat_t s;
    longint w, h, dx2, dy2, r, phi, rs;
    logic oor;
    w = clamp_dim(img_w);
    h = clamp_dim(img_h);
    dx2 = 2 * longint'(d.x) - (w - 1);
    dy2 = 2 * longint'(d.y) - (h - 1);
    r = int_sqrt((dx2 * dx2 + dy2 * dy2) <<< 16);
    phi = fold_angle(r * inv_focal);
    rs = (phi * px_per_rad) >>> 30;
    oor = 1'b0;
    s.x = SRC_W'(place_axis(dx2, w, rs, r, oor));
    s.y = SRC_W'(place_axis(dy2, h, rs, r, oor));
    s.oor = oor;
    return s;
  endfunction

  // input side: accept at posedge, present next beat at negedge
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      source_expected.push_back(remap_coord(dest_pending[0]));
      void'(dest_pending.pop_front());
      took_beat <= 1'b1;
    end else begin
      took_beat <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took_beat) begin
      if (dest_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        dest_x <= dest_pending[0].x;
        dest_y <= dest_pending[0].y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    source_beat_t e;
    if (!rst && out_valid && !out_stall) begin
      if (source_expected.size() == 0) begin
        $display("%0t: unexpected beat x=%0d y=%0d oor=%0b", $time,
                 source_x, source_y, out_of_range);
        errors++;
      end else begin
        e = source_expected.pop_front();
        n_checked++;
        if (e.oor) n_oor++;
        if (source_x !== e.x) begin
          $display("%0t: source_x expected %0d actual %0d", $time, e.x, source_x);
          errors++;
        end
        if (source_y !== e.y) begin
          $display("%0t: source_y expected %0d actual %0d", $time, e.y, source_y);
          errors++;
        end
        if (out_of_range !== e.oor) begin
          $display("%0t: out_of_range expected %0b actual %0b", $time, e.oor,
                   out_of_range);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      REG_IMAGE_WIDTH:       img_w = v & 32'h1FFF;
      REG_IMAGE_HEIGHT:      img_h = v & 32'h1FFF;
      REG_INVERSE_FOCAL:     inv_focal = v;
      REG_PIXELS_PER_RADIAN: px_per_rad = v;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_lens(input logic [12:0] w, input logic [12:0] h,
                          input logic [31:0] f, input logic [31:0] p);
    write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
    write_reg(REG_INVERSE_FOCAL, f);
    write_reg(REG_PIXELS_PER_RADIAN, p);
  endtask

  task automatic push_dest(input int x, input int y);
    dest_beat_t d;
    d.x = DEST_W'(x);
    d.y = DEST_W'(y);
    dest_pending.push_back(d);
  endtask

  // mostly inside the configured image, some anywhere in the field range
  task automatic push_random(input int n);
    int w, h;
    w = int'(clamp_dim(img_w));
    h = int'(clamp_dim(img_h));
    repeat (n) begin
      if ($urandom_range(9) < 7)
        push_dest($urandom_range(w - 1), $urandom_range(h - 1));
      else
        push_dest($urandom, $urandom);
    end
  endtask

  task automatic drain();
    while (dest_pending.size() > 0 || source_expected.size() > 0) @(negedge clk);
    repeat (110) @(negedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode % 3)
      0: begin send_idle_pct = 37; recv_idle_pct = 56; end
      1: begin send_idle_pct = 56; recv_idle_pct = 37; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    dest_x = '0;
    dest_y = '0;
    out_stall = 1'b0;
    hold_cycles = 0;
    errors = 0;
    n_checked = 0;
    n_oor = 0;
    img_w = 4096;
    img_h = 4096;
    inv_focal = 32'h0100_0000;
    px_per_rad = 32'h0001_0000;
    set_idling(0);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: corners, center, edges at reset settings
    push_dest(0, 0);
    push_dest(4095, 4095);
    push_dest(0, 4095);
    push_dest(4095, 0);
    push_dest(2047, 2047);
    push_dest(2048, 2048);
    push_dest(2047, 0);
    push_dest(0, 2048);
    drain();

    // strong lens pushes sources past every edge
    set_lens(640, 480, 32'h0000_C000, 32'h0400_0000);
    push_dest(0, 0);
    push_dest(639, 479);
    push_dest(319, 239);
    push_dest(4095, 4095);
    push_dest(320, 0);
    drain();

    // zero and oversized dimensions, zero scales
    set_lens(0, 8191, 0, 32'hFFFF_FFFF);
    push_dest(0, 0);
    push_dest(4095, 4095);
    push_dest(0, 2047);
    drain();
    set_lens(1, 1, 32'hFFFF_FFFF, 0);
    push_dest(0, 0);
    push_dest(4095, 1);
    push_dest(1, 4095);
    drain();
    set_lens(4097, 4096, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_dest(0, 0);
    push_dest(4095, 4095);
    push_dest(2048, 100);
    drain();

    // long receiver hold-off so the pipe fills and backs up the input
    set_idling(2);
    push_random(150);
    hold_cycles = 400;
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      set_idling(ph);
      case (ph % 3)
        0: set_lens($urandom_range(16, 4096), $urandom_range(16, 4096),
                    $urandom_range(8000, 200000), $urandom_range(100, 3000) << 16);
        1: set_lens($urandom_range(1, 8191), $urandom_range(1, 8191),
                    $urandom, $urandom);
        default: set_lens($urandom_range(1, 64), $urandom_range(1, 64),
                          $urandom_range(1 << 18, 1 << 22),
                          $urandom_range(1, 64) << 16);
      endcase
      push_random(100);
      drain();
    end

    if (source_expected.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time,
               source_expected.size());
      errors++;
    end
    $display("Checked %0d remapped coordinates (%0d clamped) over 14 lens settings,",
             n_checked, n_oor);
    $display("with idle input, stalled output, a long hold-off and both at full rate.");
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
